// ===== rtl/aes128_ctr_byte_stream_unit_assert.svh =====
// Assertion macros used by the back part of the AES-128 CTR byte stream RTL.
`ifndef AES128_CTR_BYTE_STREAM_UNIT_ASSERT_SVH
`define AES128_CTR_BYTE_STREAM_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ACBS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("acbs: same-cycle implication violated");

// Next-cycle implication, disabled while reset is asserted.
`define ACBS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("acbs: next-cycle implication violated");

`endif

// ===== rtl/acbs_pkg.sv =====
// Package with types, constants and AES round functions for the CTR byte stream unit.
package acbs_pkg;

  localparam int QDepth = 4;
  localparam int QIdxW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);
  localparam int Rounds = 10;

  typedef enum logic [1:0] {
    CfgKeyHigh = 2'd0,
    CfgKeyLow  = 2'd1,
    CfgIvHigh  = 2'd2,
    CfgIvLow   = 2'd3
  } cfg_idx_e;

  // One queued byte with its frame marker and the front's classification.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       first;
  } item_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [Rounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // Byte i of a 128-bit block, byte 0 in the top bits.
  function automatic logic [7:0] byte_at(input logic [127:0] v, input logic [3:0] i);
    return v[{~i, 3'b000} +: 8];
  endfunction

  // Multiplication by x in GF(2^8) with the AES polynomial.
  function automatic logic [7:0] gf_dbl(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Next round key from the previous one.
  function automatic logic [127:0] key_step(input logic [127:0] rk, input logic [7:0] rc);
    logic [31:0] t, q0, q1, q2, q3;
    t  = {SBOX[rk[23:16]] ^ rc, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
    q0 = rk[127:96] ^ t;
    q1 = rk[95:64] ^ q0;
    q2 = rk[63:32] ^ q1;
    q3 = rk[31:0] ^ q2;
    return {q0, q1, q2, q3};
  endfunction

  // One AES round: substitute, shift rows, mix columns unless final, add round key.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic final_rnd);
    logic [7:0]   t [16];
    logic [7:0]   m [16];
    logic [7:0]   a0, a1, a2, a3, al;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) begin
      t[i] = SBOX[byte_at(s, 4'(((((i >> 2) + (i & 3)) & 3) << 2) | (i & 3)))];
    end
    for (int c = 0; c < 16; c += 4) begin
      a0 = t[c];
      a1 = t[c + 1];
      a2 = t[c + 2];
      a3 = t[c + 3];
      al = a0 ^ a1 ^ a2 ^ a3;
      m[c]     = final_rnd ? a0 : (a0 ^ al ^ gf_dbl(a0 ^ a1));
      m[c + 1] = final_rnd ? a1 : (a1 ^ al ^ gf_dbl(a1 ^ a2));
      m[c + 2] = final_rnd ? a2 : (a2 ^ al ^ gf_dbl(a2 ^ a3));
      m[c + 3] = final_rnd ? a3 : (a3 ^ al ^ gf_dbl(a3 ^ a0));
    end
    for (int i = 0; i < 16; i++) begin
      r[{~4'(i), 3'b000} +: 8] = m[i] ^ byte_at(rk, 4'(i));
    end
    return r;
  endfunction

endpackage

// ===== rtl/aes128_ctr_byte_stream_unit.sv =====
// Top level of the AES-128 counter-mode byte stream unit with its configuration registers.
// Throughput: one byte per cycle in steady state unless the output is stalled; the iterative
// AES core encrypts each 16-byte keystream block one block ahead of the bytes being sent.
// Mid-message a byte passes through the input queue and the output register; the first byte
// of a message also waits while the core encrypts the initial counter.
// Reset (asynchronous, active low) empties the queue and output, and clears key and IV to zero.
module aes128_ctr_byte_stream_unit import acbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] out_byte
  output logic        m_axis_tlast_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  logic [63:0]  key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
  item_t        head;
  logic         head_vld, pop;
  logic         eng_start, eng_busy, eng_done;
  logic [127:0] eng_key, eng_ctr, eng_result;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      iv_hi_q  <= '0;
      iv_lo_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgKeyHigh: key_hi_q <= cfg_data_i;
        CfgKeyLow:  key_lo_q <= cfg_data_i;
        CfgIvHigh:  iv_hi_q  <= cfg_data_i;
        CfgIvLow:   iv_lo_q  <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  acbs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (s_axis_tvalid_i),
    .ready_o    (s_axis_tready_o),
    .data_i     (s_axis_tdata_i),
    .last_i     (s_axis_tlast_i),
    .head_vld_o (head_vld),
    .head_o     (head),
    .pop_i      (pop)
  );

  acbs_aes_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (eng_start),
    .key_i    (eng_key),
    .ctr_i    (eng_ctr),
    .busy_o   (eng_busy),
    .done_o   (eng_done),
    .result_o (eng_result)
  );

  acbs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_vld_i   (head_vld),
    .head_i       (head),
    .pop_o        (pop),
    .cfg_key_i    ({key_hi_q, key_lo_q}),
    .cfg_iv_i     ({iv_hi_q, iv_lo_q}),
    .eng_start_o  (eng_start),
    .eng_key_o    (eng_key),
    .eng_ctr_o    (eng_ctr),
    .eng_busy_i   (eng_busy),
    .eng_done_i   (eng_done),
    .eng_result_i (eng_result),
    .out_vld_o    (m_axis_tvalid_o),
    .out_rdy_i    (m_axis_tready_i),
    .out_data_o   (m_axis_tdata_o),
    .out_last_o   (m_axis_tlast_o)
  );

endmodule

// ===== rtl/acbs_queue.sv =====
// Front part: accepts input bytes, marks the first byte of each message and queues them.
module acbs_queue import acbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       ready_o,
  input  logic [7:0] data_i,
  input  logic       last_i,
  output logic       head_vld_o,
  output item_t      head_o,
  input  logic       pop_i
);

  item_t            mem_q [QDepth];
  logic [QIdxW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             first_q;
  logic             do_push;

  assign ready_o    = (cnt_q != QCntW'(QDepth));
  assign do_push    = push_i && ready_o;
  assign head_vld_o = (cnt_q != '0);
  assign head_o     = mem_q[rd_q];

  // Storage of queued items.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= '{data: data_i, last: last_i, first: first_q};
    end
  end

  // Pointers, fill level and message-start tracking.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      cnt_q   <= '0;
      first_q <= 1'b1;
    end else begin
      if (do_push) begin
        wr_q    <= wr_q + 1'b1;
        first_q <= last_i;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + QCntW'(do_push) - QCntW'(pop_i);
    end
  end

endmodule

// ===== rtl/acbs_aes_core.sv =====
// Iterative AES-128 encryption core, one round per cycle with on-the-fly key expansion.
module acbs_aes_core import acbs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] key_i,
  input  logic [127:0] ctr_i,
  output logic         busy_o,
  output logic         done_o,
  output logic [127:0] result_o
);

  logic [127:0] s_q, s_d, rk_q, rk_d;
  logic [3:0]   rnd_q, rnd_d;
  logic         busy_q, busy_d, done_q, done_d;

  // Round sequencing.
  always_comb begin
    s_d    = s_q;
    rk_d   = rk_q;
    rnd_d  = rnd_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      s_d    = ctr_i ^ key_i;
      rk_d   = key_i;
      rnd_d  = 4'd1;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rk_d  = key_step(rk_q, RCON[rnd_q - 4'd1]);
      s_d   = aes_round(s_q, rk_d, rnd_q == 4'(Rounds));
      rnd_d = rnd_q + 4'd1;
      if (rnd_q == 4'(Rounds)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s_q   <= s_d;
    rk_q  <= rk_d;
    rnd_q <= rnd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign busy_o   = busy_q || done_q;
  assign done_o   = done_q;
  assign result_o = s_q;

endmodule

// ===== rtl/acbs_back.sv =====
// Back part: keystream buffering, counter stepping, byte XOR and output register.
module acbs_back import acbs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         head_vld_i,
  input  item_t        head_i,
  output logic         pop_o,
  input  logic [127:0] cfg_key_i,
  input  logic [127:0] cfg_iv_i,
  output logic         eng_start_o,
  output logic [127:0] eng_key_o,
  output logic [127:0] eng_ctr_o,
  input  logic         eng_busy_i,
  input  logic         eng_done_i,
  input  logic [127:0] eng_result_i,
  output logic         out_vld_o,
  input  logic         out_rdy_i,
  output logic [7:0]   out_data_o,
  output logic         out_last_o
);

  `include "aes128_ctr_byte_stream_unit_assert.svh"

  logic [127:0] key_q, key_d, ctr_q, ctr_d;
  logic [127:0] cur_ks_q, cur_ks_d, nxt_ks_q, nxt_ks_d;
  logic         cur_vld_q, cur_vld_d, nxt_vld_q, nxt_vld_d;
  logic         in_msg_q, in_msg_d;
  logic [3:0]   pos_q, pos_d;
  logic         out_vld_q, out_vld_d, out_last_q, out_last_d;
  logic [7:0]   out_data_q, out_data_d;
  logic         start_msg, consume, out_free, run_next;

  // Message start, byte consumption and keystream block hand-over.
  always_comb begin
    key_d      = key_q;
    ctr_d      = ctr_q;
    cur_ks_d   = cur_ks_q;
    nxt_ks_d   = nxt_ks_q;
    cur_vld_d  = cur_vld_q;
    nxt_vld_d  = nxt_vld_q;
    in_msg_d   = in_msg_q;
    pos_d      = pos_q;
    out_vld_d  = out_vld_q;
    out_data_d = out_data_q;
    out_last_d = out_last_q;

    start_msg = head_vld_i && head_i.first && !in_msg_q;
    out_free  = !out_vld_q || out_rdy_i;
    consume   = head_vld_i && in_msg_q && cur_vld_q && out_free;
    run_next  = in_msg_q && !eng_busy_i && !(cur_vld_q && nxt_vld_q);

    eng_start_o = start_msg || run_next;
    eng_key_o   = start_msg ? cfg_key_i : key_q;
    eng_ctr_o   = start_msg ? cfg_iv_i : ctr_q;

    if (start_msg) begin
      key_d     = cfg_key_i;
      ctr_d     = cfg_iv_i + 128'd1;
      in_msg_d  = 1'b1;
      cur_vld_d = 1'b0;
      nxt_vld_d = 1'b0;
      pos_d     = '0;
    end else if (run_next) begin
      ctr_d = ctr_q + 128'd1;
    end

    // Output register takes a new transfer when free.
    if (consume) begin
      out_vld_d  = 1'b1;
      out_data_d = head_i.data ^ byte_at(cur_ks_q, pos_q);
      out_last_d = head_i.last;
      pos_d      = pos_q + 4'd1;
      if (head_i.last) begin
        in_msg_d  = 1'b0;
        cur_vld_d = 1'b0;
        nxt_vld_d = 1'b0;
      end else if (pos_q == 4'hf) begin
        cur_ks_d  = nxt_ks_q;
        cur_vld_d = nxt_vld_q;
        nxt_vld_d = 1'b0;
      end
    end else if (out_rdy_i) begin
      out_vld_d = 1'b0;
    end

    // A finished block fills the first free buffer while the message runs and is not ending now.
    if (eng_done_i && in_msg_q && !(consume && head_i.last)) begin
      if (!cur_vld_d) begin
        cur_ks_d  = eng_result_i;
        cur_vld_d = 1'b1;
      end else begin
        nxt_ks_d  = eng_result_i;
        nxt_vld_d = 1'b1;
      end
    end
  end

  assign pop_o = consume;

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    ctr_q      <= ctr_d;
    cur_ks_q   <= cur_ks_d;
    nxt_ks_q   <= nxt_ks_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      nxt_vld_q <= 1'b0;
      in_msg_q  <= 1'b0;
      pos_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      cur_vld_q <= cur_vld_d;
      nxt_vld_q <= nxt_vld_d;
      in_msg_q  <= in_msg_d;
      pos_q     <= pos_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_vld_o  = out_vld_q;
  assign out_data_o = out_data_q;
  assign out_last_o = out_last_q;

  `ACBS_ASSERT_IMP(a_nxt_needs_cur, clk_i, rst_ni, nxt_vld_q, cur_vld_q)
  `ACBS_ASSERT_IMP(a_no_spill, clk_i, rst_ni, eng_done_i && in_msg_q, !(cur_vld_q && nxt_vld_q))
  `ACBS_ASSERT_NXT(a_start_clears, clk_i, rst_ni, start_msg, in_msg_q && !cur_vld_q && pos_q == 4'd0)
  `ACBS_ASSERT_IMP(a_stall_no_consume, clk_i, rst_ni, out_vld_q && !out_rdy_i, !consume)

endmodule

// ===== tb/aes_ctr_checker.sv =====
// Checker for the AES-128 CTR byte stream unit: predicts output bytes and compares them.
`timescale 1ns / 1ps
module aes_ctr_checker import acbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [7:0]  s_data_i,
  input  logic        s_last_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [7:0]  m_data_i,
  input  logic        m_last_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [7:0] byte_val;
    logic       last;
  } cipher_out_t;

  // Sbox copied as data, round logic written afresh below.
  localparam logic [7:0] SUB [256] = SBOX;
  localparam logic [7:0] RC [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                     8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

  logic [63:0]  key_hi, key_lo, iv_hi, iv_lo;
  logic [7:0]   rkeys [11][16];
  logic [7:0]   ctr [16];
  logic [7:0]   stream [16];
  logic [3:0]   pos;
  logic         busy;
  cipher_out_t  expected_bytes [$];
  int           fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_bytes.size();

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Expand the key registers into the eleven round keys.
  task automatic build_round_keys();
    logic [7:0] t [4];
    for (int i = 0; i < 8; i++) begin
      rkeys[0][i]     = key_hi[56 - 8 * i +: 8];
      rkeys[0][8 + i] = key_lo[56 - 8 * i +: 8];
    end
    for (int r = 1; r <= 10; r++) begin
      t[0] = SUB[rkeys[r-1][13]] ^ RC[r-1];
      t[1] = SUB[rkeys[r-1][14]];
      t[2] = SUB[rkeys[r-1][15]];
      t[3] = SUB[rkeys[r-1][12]];
      for (int i = 0; i < 16; i++) begin
        rkeys[r][i] = rkeys[r-1][i] ^ t[i & 3];
        t[i & 3] = rkeys[r][i];
      end
    end
  endtask

  // Encrypt the counter into the keystream block.
  task automatic make_keystream();
    logic [7:0] s [16];
    logic [7:0] w [16];
    logic [7:0] a0, a1, a2, a3, al;
    for (int i = 0; i < 16; i++) s[i] = ctr[i] ^ rkeys[0][i];
    for (int r = 1; r <= 10; r++) begin
      for (int i = 0; i < 16; i++) w[i] = SUB[s[((((i >> 2) + (i & 3)) & 3) << 2) | (i & 3)]];
      if (r != 10) begin
        for (int c = 0; c < 16; c += 4) begin
          a0 = w[c]; a1 = w[c+1]; a2 = w[c+2]; a3 = w[c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          w[c]   = a0 ^ al ^ xtime(a0 ^ a1);
          w[c+1] = a1 ^ al ^ xtime(a1 ^ a2);
          w[c+2] = a2 ^ al ^ xtime(a2 ^ a3);
          w[c+3] = a3 ^ al ^ xtime(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = w[i] ^ rkeys[r][i];
    end
    stream = s;
  endtask

  // Predict the output byte for one input transfer.
  task automatic predict_byte(input logic [7:0] b, input logic l);
    cipher_out_t e;
    logic carry;
    if (!busy) begin
      build_round_keys();
      for (int i = 0; i < 8; i++) begin
        ctr[i]     = iv_hi[56 - 8 * i +: 8];
        ctr[8 + i] = iv_lo[56 - 8 * i +: 8];
      end
      pos = 4'd0;
      make_keystream();
      busy = 1'b1;
    end
    e.byte_val = b ^ stream[pos];
    e.last     = l;
    expected_bytes.insert(expected_bytes.size(), e);
    pos = pos + 4'd1;
    if (pos == 4'd0) begin
      carry = 1'b1;
      for (int i = 15; i >= 0; i--) begin
        if (carry) begin
          ctr[i] = ctr[i] + 8'd1;
          carry  = (ctr[i] == 8'd0);
        end
      end
      make_keystream();
    end
    if (l) busy = 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cipher_out_t e;
    if (!rst_ni) begin
      key_hi <= '0; key_lo <= '0; iv_hi <= '0; iv_lo <= '0;
      busy = 1'b0;
      pos  = 4'd0;
      fails = 0;
      expected_bytes.delete();
    end else begin
      // Register writes.
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgKeyHigh: key_hi <= cfg_data_i;
          CfgKeyLow:  key_lo <= cfg_data_i;
          CfgIvHigh:  iv_hi  <= cfg_data_i;
          CfgIvLow:   iv_lo  <= cfg_data_i;
          default: ;
        endcase
      end
      // Output transfer is checked against the oldest prediction.
      if (m_valid_i && m_ready_i) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected output transfer: out_byte %h", m_data_i);
          fails++;
        end else begin
          e = expected_bytes.pop_front();
          if (m_data_i !== e.byte_val) begin
            $error("out_byte expected %h actual %h", e.byte_val, m_data_i);
            fails++;
          end
          if (m_last_i !== e.last) begin
            $error("out_last expected %b actual %b", e.last, m_last_i);
            fails++;
          end
        end
      end
      if (s_valid_i && s_ready_i) predict_byte(s_data_i, s_last_i);
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the testbench: clock, reset, stimulus and verdict for the AES-128 CTR stream unit.
`timescale 1ns / 1ps
module testbench;
  import acbs_pkg::*;

  localparam int StallLimit = 4000;

  logic        clk, rst_n;
  logic        s_valid, s_ready, s_last;
  logic [7:0]  s_data;
  logic        m_valid, m_ready, m_last;
  logic [7:0]  m_data;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [63:0] cfg_data;
  int          fail_count, pending;
  int          send_idle_pct, recv_idle_pct;
  int          hold_off_cycles;
  int          idle_cycles;
  bit          held_off;

  aes128_ctr_byte_stream_unit dut (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tlast_i(s_last),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tlast_o(m_last),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  aes_ctr_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .s_valid_i(s_valid), .s_ready_i(s_ready), .s_data_i(s_data), .s_last_i(s_last),
    .m_valid_i(m_valid), .m_ready_i(m_ready), .m_data_i(m_data), .m_last_i(m_last),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, or a long hold-off when asked for.
  initial begin
    m_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        m_ready <= 1'b0;
        hold_off_cycles--;
      end else begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles with no transfer at all.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((s_valid && s_ready) || (m_valid && m_ready) || hold_off_cycles > 0) idle_cycles = 0;
      else if (pending > 0 || s_valid) idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stop offering, wait until every predicted byte has come out, then let the core settle.
  task automatic drain();
    s_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
  endtask

  // Offer one byte and hold it until it is taken; the next byte may follow directly.
  task automatic send_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_last  <= l;
    do @(posedge clk); while (!s_ready);
  endtask

  task automatic send_message(input int len, input bit fixed, input logic [7:0] val);
    for (int i = 0; i < len; i++)
      send_byte(fixed ? val : 8'($urandom), i == len - 1);
  endtask

  task automatic set_key_iv(input logic [63:0] kh, kl, ih, il);
    write_reg(CfgKeyHigh, kh);
    write_reg(CfgKeyLow, kl);
    write_reg(CfgIvHigh, ih);
    write_reg(CfgIvLow, il);
  endtask

  initial begin
    int sent;
    rst_n = 1'b0;
    s_valid = 1'b0; s_data = '0; s_last = 1'b0;
    cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
    send_idle_pct = 26; recv_idle_pct = 74; hold_off_cycles = 0;
    held_off = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero key and IV, byte extremes, single-byte message, partial block.
    send_message(1, 1, 8'h00);
    send_message(3, 1, 8'hff);
    drain();
    // Counter wrap across a block boundary with all-ones IV.
    set_key_iv('1, '1, '1, '1);
    send_message(20, 0, 8'h00);
    drain();
    set_key_iv(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
               64'h0000000000000000, 64'hfffffffffffffffe);
    send_byte(8'h55, 1'b0);
    // A write in mid-message, with nothing in flight, only affects the next message.
    drain();
    write_reg(CfgKeyHigh, 64'hdeadbeefcafef00d);
    send_byte(8'haa, 1'b1);
    drain();

    // Random messages over three idling phases.
    sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 74 : 0;
      recv_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 26 : 0;
      drain();
      set_key_iv({$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
      while (sent < (phase + 1) * 160) begin
        int len;
        len = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
        if (phase == 2 && sent > 400 && !held_off) begin
          hold_off_cycles = 200;
          held_off = 1'b1;
        end
        send_message(len, 0, 8'h00);
        sent += len;
        if ($urandom_range(4) == 0) begin
          drain();
          write_reg(cfg_idx_e'($urandom_range(3)), {$urandom, $urandom});
        end
      end
    end

    drain();
    repeat (30) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
